// ===== sv/cif_pkg.sv =====
`default_nettype none
package cif_pkg;

   localparam logic signed [17:0] E_REST = -18'sd73400;
   localparam logic signed [17:0] E_INH  = -18'sd83886;
   localparam logic [23:0]        G_MAX  = 24'hFFFFFF;
   localparam logic [16:0]        ONE_Q16 = 17'd65536;

   typedef enum logic [1:0] {
      KIND_TICK = 2'd0,
      KIND_EXC  = 2'd1,
      KIND_INH  = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_AMPA_DECAY        = 3'd0,
      REG_GABA_DECAY        = 3'd1,
      REG_THRESHOLD_DECAY   = 3'd2,
      REG_NMDA_RATE         = 3'd3,
      REG_MEMBRANE_RATE     = 3'd4,
      REG_AMPA_SHARE        = 3'd5,
      REG_RESTING_THRESHOLD = 3'd6,
      REG_THRESHOLD_JUMP    = 3'd7
   } reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVENT,
      ST_TICK,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic signed [17:0] v;
      logic [19:0]        th;
      logic [23:0]        ga;
      logic [23:0]        gg;
      logic [23:0]        gn;
   } neuron_type;

   typedef struct packed {
      logic [15:0]        ampa_decay;
      logic [15:0]        gaba_decay;
      logic [15:0]        threshold_decay;
      logic [15:0]        nmda_rate;
      logic [15:0]        membrane_rate;
      logic [16:0]        ampa_share;
      logic signed [20:0] resting_threshold;
      logic [19:0]        threshold_jump;
   } cfg_type;

   localparam neuron_type NEURON_RESET = '{v: E_REST, th: 20'd0, ga: 24'd0,
                                           gg: 24'd0, gn: 24'd0};

endpackage
`default_nettype wire

// ===== sv/cif_mem.sv =====
`default_nettype none
module cif_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rd_en,
   input  wire logic [AW-1:0]       rd_addr,
   output cif_pkg::neuron_type      rd_data,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  cif_pkg::neuron_type      wr_data
);
   import cif_pkg::*;

   neuron_type       mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   neuron_type       rd_q_ff;
   logic             rd_ok_ff;

   // Entries never written read as the reset state of a neuron.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_ok_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_ok_ff ? rd_q_ff : NEURON_RESET;

endmodule
`default_nettype wire

// ===== sv/cif_pipe.sv =====
`default_nettype none
module cif_pipe (
   input  wire logic                clock,
   input  wire logic                reset,
   input  cif_pkg::cfg_type         cfg,
   input  wire logic                in_valid,
   input  wire logic [5:0]          in_idx,
   input  wire logic                in_last,
   input  cif_pkg::neuron_type      in_neuron,
   output logic                     wr_en,
   output logic [5:0]               wr_idx,
   output cif_pkg::neuron_type      wr_data,
   output logic                     busy,
   output logic                     rsp_valid,
   output logic [5:0]               rsp_neuron_index,
   output logic                     rsp_spiked,
   output logic signed [17:0]       rsp_membrane,
   output logic                     rsp_last
);
   import cif_pkg::*;

   // Stage A: all products of the old state.
   logic               a_valid_ff, a_last_ff;
   logic [5:0]         a_idx_ff;
   logic signed [17:0] a_v_ff;
   logic [23:0]        a_gn_ff;
   logic [40:0]        a_pa_ff, a_pn_ff, a_pinh_ff;
   logic [39:0]        a_pm_ff, a_pgad_ff, a_pggd_ff;
   logic [35:0]        a_pthd_ff;
   logic [16:0]        a_share;
   logic [16:0]        a_vinh;
   logic signed [17:0] a_vdiff;

   always_comb begin
      a_share = (cfg.ampa_share > ONE_Q16) ? ONE_Q16 : cfg.ampa_share;
      a_vdiff = in_neuron.v - E_INH;
      a_vinh  = a_vdiff[16:0];
   end

   always_ff @(posedge clock) begin
      a_idx_ff  <= in_idx;
      a_last_ff <= in_last;
      a_v_ff    <= in_neuron.v;
      a_gn_ff   <= in_neuron.gn;
      a_pa_ff   <= 41'(a_share) * 41'(in_neuron.ga);
      a_pn_ff   <= 41'(17'(ONE_Q16 - a_share)) * 41'(in_neuron.gn);
      a_pm_ff   <= 40'(cfg.nmda_rate) * 40'(in_neuron.ga);
      a_pgad_ff <= 40'(cfg.ampa_decay) * 40'(in_neuron.ga);
      a_pggd_ff <= 40'(cfg.gaba_decay) * 40'(in_neuron.gg);
      a_pthd_ff <= 36'(cfg.threshold_decay) * 36'(in_neuron.th);
      a_pinh_ff <= 41'(a_vinh) * 41'(in_neuron.gg);
   end

   // Stage B: scale products back, NMDA input sum, leak.
   logic               b_valid_ff, b_last_ff;
   logic [5:0]         b_idx_ff;
   logic signed [17:0] b_v_ff;
   logic [23:0]        b_gmix_ff, b_ga_ff, b_gg_ff;
   logic [19:0]        b_th_ff;
   logic [24:0]        b_t_ff, b_inh_ff;
   logic signed [17:0] b_leak_ff;
   logic [41:0]        b_mix_sum;

   assign b_mix_sum = 42'(a_pa_ff) + 42'(a_pn_ff);

   always_ff @(posedge clock) begin
      b_idx_ff  <= a_idx_ff;
      b_last_ff <= a_last_ff;
      b_v_ff    <= a_v_ff;
      b_gmix_ff <= b_mix_sum[39:16];
      b_t_ff    <= 25'(a_gn_ff) + 25'(a_pm_ff[39:16]);
      b_ga_ff   <= a_pgad_ff[39:16];
      b_gg_ff   <= a_pggd_ff[39:16];
      b_th_ff   <= a_pthd_ff[35:16];
      b_inh_ff  <= a_pinh_ff[40:16];
      b_leak_ff <= a_v_ff - E_REST;
   end

   // Stage C: excitatory current product and NMDA decay product.
   logic               c_valid_ff, c_last_ff;
   logic [5:0]         c_idx_ff;
   logic signed [17:0] c_v_ff, c_leak_ff;
   logic [23:0]        c_ga_ff, c_gg_ff;
   logic [19:0]        c_th_ff;
   logic [24:0]        c_t_ff, c_inh_ff;
   logic [40:0]        c_pexc_ff, c_pmt_ff;
   logic signed [17:0] c_negv;

   assign c_negv = -b_v_ff;

   always_ff @(posedge clock) begin
      c_idx_ff  <= b_idx_ff;
      c_last_ff <= b_last_ff;
      c_v_ff    <= b_v_ff;
      c_leak_ff <= b_leak_ff;
      c_ga_ff   <= b_ga_ff;
      c_gg_ff   <= b_gg_ff;
      c_th_ff   <= b_th_ff;
      c_t_ff    <= b_t_ff;
      c_inh_ff  <= b_inh_ff;
      c_pexc_ff <= 41'(b_gmix_ff) * 41'(c_negv[16:0]);
      c_pmt_ff  <= 41'(cfg.nmda_rate) * 41'(b_t_ff);
   end

   // Stage D: net drive and saturated NMDA update.
   logic               d_valid_ff, d_last_ff;
   logic [5:0]         d_idx_ff;
   logic signed [17:0] d_v_ff;
   logic [23:0]        d_ga_ff, d_gg_ff, d_gn_ff;
   logic [19:0]        d_th_ff;
   logic signed [27:0] d_diff_ff;
   logic [24:0]        d_gnn;
   logic signed [27:0] d_diff_in;

   always_comb begin
      d_gnn     = c_t_ff - c_pmt_ff[40:16];
      d_diff_in = 28'(signed'({1'b0, c_pexc_ff[40:16]}))
                - 28'(signed'({1'b0, c_inh_ff}))
                - 28'(c_leak_ff);
   end

   always_ff @(posedge clock) begin
      d_idx_ff  <= c_idx_ff;
      d_last_ff <= c_last_ff;
      d_v_ff    <= c_v_ff;
      d_ga_ff   <= c_ga_ff;
      d_gg_ff   <= c_gg_ff;
      d_th_ff   <= c_th_ff;
      d_gn_ff   <= d_gnn[24] ? G_MAX : d_gnn[23:0];
      d_diff_ff <= d_diff_in;
   end

   // Stage E: Euler step product.
   logic               e_valid_ff, e_last_ff;
   logic [5:0]         e_idx_ff;
   logic signed [17:0] e_v_ff;
   logic [23:0]        e_ga_ff, e_gg_ff, e_gn_ff;
   logic [19:0]        e_th_ff;
   logic signed [44:0] e_kprod_ff;

   always_ff @(posedge clock) begin
      e_idx_ff   <= d_idx_ff;
      e_last_ff  <= d_last_ff;
      e_v_ff     <= d_v_ff;
      e_ga_ff    <= d_ga_ff;
      e_gg_ff    <= d_gg_ff;
      e_gn_ff    <= d_gn_ff;
      e_th_ff    <= d_th_ff;
      e_kprod_ff <= 45'(signed'({1'b0, cfg.membrane_rate})) * 45'(d_diff_ff);
   end

   // Final step: integrate, clip, threshold test, write back.
   logic signed [28:0] f_step;
   logic signed [29:0] f_vn;
   logic signed [17:0] f_vclip, f_vfin;
   logic signed [21:0] f_thr;
   logic               f_spike;
   logic [19:0]        f_thfin;

   always_comb begin
      f_step  = e_kprod_ff[44:16];
      f_vn    = 30'(e_v_ff) + 30'(f_step);
      if (f_vn < 30'(E_INH)) begin
         f_vclip = E_INH;
      end else if (f_vn > 30'sd0) begin
         f_vclip = 18'sd0;
      end else begin
         f_vclip = f_vn[17:0];
      end
      f_thr   = 22'(cfg.resting_threshold) + 22'(signed'({1'b0, e_th_ff}));
      f_spike = 22'(f_vclip) > f_thr;
      f_vfin  = f_spike ? E_REST : f_vclip;
      f_thfin = f_spike ? cfg.threshold_jump : e_th_ff;
   end

   assign wr_en   = e_valid_ff;
   assign wr_idx  = e_idx_ff;
   assign wr_data = '{v: f_vfin, th: f_thfin, ga: e_ga_ff, gg: e_gg_ff, gn: e_gn_ff};

   logic               rsp_valid_ff, rsp_spiked_ff, rsp_last_ff;
   logic [5:0]         rsp_idx_ff;
   logic signed [17:0] rsp_membrane_ff;

   always_ff @(posedge clock) begin
      rsp_idx_ff      <= e_idx_ff;
      rsp_spiked_ff   <= f_spike;
      rsp_membrane_ff <= f_vfin;
      rsp_last_ff     <= e_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= in_valid;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         e_valid_ff   <= d_valid_ff;
         rsp_valid_ff <= e_valid_ff;
      end
   end

   assign busy             = a_valid_ff | b_valid_ff | c_valid_ff | d_valid_ff | e_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_neuron_index = rsp_idx_ff;
   assign rsp_spiked       = rsp_spiked_ff;
   assign rsp_membrane     = rsp_membrane_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
`default_nettype wire

// ===== sv/conductance_if_neuron_array.sv =====
`default_nettype none
// Array of conductance-based integrate-and-fire neurons.
//
// A word is presented on req_kind, req_neuron and req_weight with start high;
// it is taken at a clock edge where busy is low. An excitatory or inhibitory
// word adds req_weight, saturating, to the target neuron's AMPA or GABA
// conductance; it keeps busy high for one cycle and yields no result. A word
// of unused kind, or an event for a neuron at or beyond NEURONS, is dropped.
// A tick word updates all NEURONS neurons in index order, one per cycle, and
// yields one result word per neuron on the rsp_ ports, marked by rsp_valid for
// a single cycle; rsp_last flags the final neuron. Each neuron passes the
// memory read register, arithmetic stages A to E and a response register;
// busy stays high until the last neuron is written back. The rate is set by
// the single read port of the neuron state memory; the pipeline writes back.
// The receiver cannot stall; every result must be taken when shown.
// Configuration registers are written through csr_we, csr_index and csr_wdata
// by the user only while busy is low; the block does not enforce it. A
// synchronous reset restores register defaults and rests all neurons at once.
module conductance_if_neuron_array #(
   parameter int NEURONS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_kind,
   input  wire logic [5:0]         req_neuron,
   input  wire logic [23:0]        req_weight,
   output logic                    rsp_valid,
   output logic [5:0]              rsp_neuron_index,
   output logic                    rsp_spiked,
   output logic signed [17:0]      rsp_membrane,
   output logic                    rsp_last,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [20:0]        csr_wdata
);
   import cif_pkg::*;

   localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

   // Configuration registers.
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ampa_decay        <= 16'd64238;
         cfg_ff.gaba_decay        <= 16'd64884;
         cfg_ff.threshold_decay   <= 16'd64238;
         cfg_ff.nmda_rate         <= 16'd66;
         cfg_ff.membrane_rate     <= 16'd328;
         cfg_ff.ampa_share        <= 17'd32768;
         cfg_ff.resting_threshold <= -21'sd52429;
         cfg_ff.threshold_jump    <= 20'd104858;
      end else if (csr_we) begin
         unique case (reg_type'(csr_index))
            REG_AMPA_DECAY:        cfg_ff.ampa_decay        <= csr_wdata[15:0];
            REG_GABA_DECAY:        cfg_ff.gaba_decay        <= csr_wdata[15:0];
            REG_THRESHOLD_DECAY:   cfg_ff.threshold_decay   <= csr_wdata[15:0];
            REG_NMDA_RATE:         cfg_ff.nmda_rate         <= csr_wdata[15:0];
            REG_MEMBRANE_RATE:     cfg_ff.membrane_rate     <= csr_wdata[15:0];
            REG_AMPA_SHARE:        cfg_ff.ampa_share        <= csr_wdata[16:0];
            REG_RESTING_THRESHOLD: cfg_ff.resting_threshold <= signed'(csr_wdata);
            REG_THRESHOLD_JUMP:    cfg_ff.threshold_jump    <= csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   // Sequencer state.
   state_type   state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        s0_valid_ff, s0_valid_in;
   logic        s0_last_ff;
   logic [5:0]  s0_idx_ff;
   logic        ev_inh_ff;
   logic [AW-1:0] ev_addr_ff;
   logic [23:0] ev_weight_ff;

   logic          accept;
   logic          in_range;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   neuron_type    rd_data;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   neuron_type    mem_wdata;

   logic          pipe_wr_en;
   logic [5:0]    pipe_wr_idx;
   neuron_type    pipe_wr_data;
   logic          pipe_busy;

   assign accept   = start && !busy;
   assign in_range = {1'b0, req_neuron} < 7'(NEURONS);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      s0_valid_in = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = cnt_ff[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (kind_type'(req_kind))
                  KIND_TICK: begin
                     state_in = ST_TICK;
                     cnt_in   = 6'd0;
                  end
                  KIND_EXC, KIND_INH: begin
                     if (in_range) begin
                        state_in = ST_EVENT;
                        rd_en    = 1'b1;
                        rd_addr  = req_neuron[AW-1:0];
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_EVENT: begin
            state_in = ST_IDLE;
         end
         ST_TICK: begin
            rd_en       = 1'b1;
            s0_valid_in = 1'b1;
            if (cnt_ff == 6'(NEURONS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_DRAIN: begin
            if (!s0_valid_ff && !pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= 6'd0;
         s0_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_idx_ff  <= cnt_ff;
      s0_last_ff <= (cnt_ff == 6'(NEURONS - 1));
      if (accept) begin
         ev_inh_ff    <= (req_kind == KIND_INH);
         ev_addr_ff   <= req_neuron[AW-1:0];
         ev_weight_ff <= req_weight;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // Event read-modify-write: the read was issued when the word was taken.
   logic [23:0] ev_old;
   logic [24:0] ev_sum;
   logic [23:0] ev_new;

   always_comb begin
      ev_old    = ev_inh_ff ? rd_data.gg : rd_data.ga;
      ev_sum    = 25'(ev_old) + 25'(ev_weight_ff);
      ev_new    = ev_sum[24] ? G_MAX : ev_sum[23:0];
      mem_wdata = rd_data;
      if (ev_inh_ff) begin
         mem_wdata.gg = ev_new;
      end else begin
         mem_wdata.ga = ev_new;
      end
      if (state_ff != ST_EVENT) begin
         mem_wdata = pipe_wr_data;
      end
      mem_we    = (state_ff == ST_EVENT) || pipe_wr_en;
      mem_waddr = (state_ff == ST_EVENT) ? ev_addr_ff : pipe_wr_idx[AW-1:0];
   end

   cif_mem #(
      .DEPTH (NEURONS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata)
   );

   cif_pipe u_pipe (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .in_valid         (s0_valid_ff),
      .in_idx           (s0_idx_ff),
      .in_last          (s0_last_ff),
      .in_neuron        (rd_data),
      .wr_en            (pipe_wr_en),
      .wr_idx           (pipe_wr_idx),
      .wr_data          (pipe_wr_data),
      .busy             (pipe_busy),
      .rsp_valid        (rsp_valid),
      .rsp_neuron_index (rsp_neuron_index),
      .rsp_spiked       (rsp_spiked),
      .rsp_membrane     (rsp_membrane),
      .rsp_last         (rsp_last)
   );

   // Reported voltages always lie inside the clipping window.
   a_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_membrane >= E_INH) && (rsp_membrane <= 18'sd0))
      else $error("membrane outside clip range");

   // A neuron that fires reports the reset potential.
   a_spike_reset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_spiked |-> rsp_membrane == E_REST)
      else $error("spiking neuron not reset");

   // The last flag belongs to the final neuron only.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_neuron_index == 6'(NEURONS - 1))
      else $error("last flag on wrong neuron");

   // A tick that is taken occupies the block in the following cycle.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_kind == KIND_TICK |=> busy)
      else $error("tick taken without going busy");

endmodule
`default_nettype wire
